[rtl/depq_pkg.sv]
// Shared types and codes for the double-ended priority queue.
// No dependencies.
package depq_pkg;

	localparam logic [1:0] FUNC_INSERT  = 2'd0;
	localparam logic [1:0] FUNC_EXT_MIN = 2'd1;
	localparam logic [1:0] FUNC_EXT_MAX = 2'd2;
	localparam logic [1:0] FUNC_NONE    = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} depq_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
	} depq_out_t;

endpackage

[rtl/depq_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module depq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[rtl/double_ended_priority_queue_unit.sv]
// Double-ended priority queue: a min heap and a max heap with cross links.
// Each item is an insert, an extract-min, an extract-max or an unused code, and gives one result.
// Channels: in (in_valid/in_stall/in_data) and out (out_valid/out_stall/out_data),
// with a transfer at each edge where valid is high and stall low.
// One item is worked at a time by a sequencer over four single-port RAMs
// (value and link per heap). A sift-up level reads the parent, compares and
// moves; a sift-down level reads the left child, reads the right child,
// compares and moves. An insert sifts up in both heaps; an extract sifts the
// extracted heap down and repairs the partner slot in the other heap. Empty,
// full and unused operations set their result directly from the idle state.
// The result register is taken at the first edge without stall; the next item
// can transfer only after that.
// in_stall is high while an item is in work and while its result waits.
// A stalled result holds in the output register until taken.
// Reset empties the queue: entry count and control state clear; the RAMs
// need no clearing pass since only entries below the count are ever used.
module double_ended_priority_queue_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  depq_pkg::depq_in_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output depq_pkg::depq_out_t out_data
);
	import depq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_ROOT   = 12'b000000000010, // read root of the extracted heap
		ST_ROOTW  = 12'b000000000100, // latch root, read last entry
		ST_RDLAST = 12'b000000001000, // read last entry of the other heap
		ST_LAST   = 12'b000000010000, // latch last entry as the one to place
		ST_UP     = 12'b000000100000, // read parent
		ST_UPC    = 12'b000001000000, // compare with parent
		ST_DNL    = 12'b000010000000, // read left child
		ST_DNR    = 12'b000100000000, // latch left, read right child
		ST_DNC    = 12'b001000000000, // compare with best child
		ST_MOVE   = 12'b010000000000, // move neighbor into hole
		ST_PLACE  = 12'b100000000000  // write entry into hole
	} state_t;

	state_t state_q;
	logic [1:0] func_q;
	logic [CW-1:0] count_q;
	logic mx_q;                     // heap being worked: 1 max heap
	logic pass2_q;                  // second heap of this item
	logic [AW-1:0] hole_q;          // current hole position
	logic [31:0] cur_val_q;         // entry being placed
	logic [AW-1:0] cur_link_q;
	logic [AW-1:0] nb_pos_q;        // neighbor (parent or child) position
	logic [31:0] nb_val_q;
	logic [AW-1:0] nb_link_q;
	logic [AW-1:0] partner_q;
	logic [AW-1:0] last_q;          // last index of the heap being resized
	logic [CW-1:0] size_q;          // entries in the heap during sift
	logic [31:0] res_q;
	logic up_done_q;                // sift-up moved the hole
	logic [31:0] left_val_q;
	logic [AW-1:0] left_link_q;
	depq_out_t out_q;
	logic out_valid_q;

	// Four RAMs: value and own link per heap
	logic we_min, we_max, wel_min, wel_max;
	logic [AW-1:0] a_min, a_max;
	logic [31:0] wd_min, wd_max, rd_min_v, rd_max_v;
	logic [AW-1:0] wl_min, wl_max, rl_min, rl_max;

	// Port requests seen from the worked heap (x) and the other heap (y)
	logic [AW-1:0] x_addr, y_addr;
	logic x_we, y_we;
	logic [31:0] x_wd;
	logic [AW-1:0] x_wl, y_wl;

	logic [31:0] rv;
	logic [AW-1:0] rl;
	logic [AW+1:0] lc_w, rc_w, size_ext;
	logic [AW-1:0] parent;
	logic right_ok, take_right;
	logic [31:0] best_val;
	logic [AW-1:0] best_link, best_pos;

	depq_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_min_val (.clk, .we(we_min), .addr(a_min),
		.wdata(wd_min), .rdata(rd_min_v));
	depq_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_max_val (.clk, .we(we_max), .addr(a_max),
		.wdata(wd_max), .rdata(rd_max_v));
	depq_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_min_lnk (.clk, .we(wel_min), .addr(a_min),
		.wdata(wl_min), .rdata(rl_min));
	depq_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_max_lnk (.clk, .we(wel_max), .addr(a_max),
		.wdata(wl_max), .rdata(rl_max));

	// Signed order in the direction of the working heap
	function automatic logic goes_first(input logic [31:0] a, input logic [31:0] b,
			input logic mx);
		return mx ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	// Read data of the worked heap
	assign rv = mx_q ? rd_max_v : rd_min_v;
	assign rl = mx_q ? rl_max : rl_min;

	// Child positions, widened to compare with the heap size, and the parent position
	assign lc_w = {1'b0, hole_q, 1'b1};
	assign rc_w = lc_w + (AW+2)'(1);
	assign size_ext = (AW+2)'(size_q);
	assign parent = (hole_q - AW'(1)) >> 1;

	// Pick the child that goes first
	assign right_ok = rc_w < size_ext;
	assign take_right = right_ok && goes_first(rv, left_val_q, mx_q);
	assign best_val = take_right ? rv : left_val_q;
	assign best_link = take_right ? rl : left_link_q;
	assign best_pos = take_right ? AW'(rc_w) : AW'(lc_w);

	// RAM requests per state
	always_comb begin
		x_addr = '0; x_we = 1'b0; x_wd = cur_val_q; x_wl = cur_link_q;
		y_addr = cur_link_q; y_we = 1'b0; y_wl = hole_q;
		case (state_q)
			ST_ROOTW, ST_RDLAST: begin
				x_addr = last_q;
			end
			ST_UP: begin
				x_addr = parent;
			end
			ST_DNL: begin
				x_addr = AW'(lc_w);
			end
			ST_DNR: begin
				x_addr = AW'(rc_w);
			end
			ST_MOVE: begin
				// neighbor goes to the hole; its partner link follows
				x_addr = hole_q; x_we = 1'b1; x_wd = nb_val_q; x_wl = nb_link_q;
				y_addr = nb_link_q; y_we = 1'b1;
			end
			ST_PLACE: begin
				x_addr = hole_q; x_we = 1'b1;
				y_addr = cur_link_q; y_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Map worked/other heap requests onto the min and max RAMs
	assign a_min = mx_q ? y_addr : x_addr;
	assign a_max = mx_q ? x_addr : y_addr;
	assign we_min = x_we & ~mx_q;
	assign we_max = x_we & mx_q;
	assign wel_min = mx_q ? y_we : x_we;
	assign wel_max = mx_q ? x_we : y_we;
	assign wd_min = x_wd;
	assign wd_max = x_wd;
	assign wl_min = mx_q ? y_wl : x_wl;
	assign wl_max = mx_q ? x_wl : y_wl;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q <= '0;
			count_q <= '0;
			mx_q <= 1'b0;
			pass2_q <= 1'b0;
			hole_q <= '0;
			cur_val_q <= '0;
			cur_link_q <= '0;
			nb_pos_q <= '0;
			nb_val_q <= '0;
			nb_link_q <= '0;
			partner_q <= '0;
			last_q <= '0;
			size_q <= '0;
			res_q <= '0;
			up_done_q <= 1'b0;
			left_val_q <= '0;
			left_link_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= in_data.func;
						cur_val_q <= in_data.value;
						res_q <= '0;
						pass2_q <= 1'b0;
						up_done_q <= 1'b0;
						if (in_data.func == FUNC_INSERT) begin
							if (count_q == CAP_C) begin
								out_q <= '{result_value: '0, status: STATUS_FULL};
								out_valid_q <= 1'b1;
							end else begin
								// new entry starts at the end of the min heap
								mx_q <= 1'b0;
								hole_q <= AW'(count_q);
								cur_link_q <= AW'(count_q);
								last_q <= AW'(count_q);
								size_q <= count_q + 1'b1;
								count_q <= count_q + 1'b1;
								state_q <= (count_q != '0) ? ST_UP : ST_PLACE;
							end
						end else if (in_data.func == FUNC_EXT_MIN ||
								in_data.func == FUNC_EXT_MAX) begin
							if (count_q == '0) begin
								out_q <= '{result_value: '0, status: STATUS_EMPTY};
								out_valid_q <= 1'b1;
							end else begin
								mx_q <= (in_data.func == FUNC_EXT_MAX);
								last_q <= AW'(count_q - 1'b1);
								size_q <= count_q - 1'b1;
								count_q <= count_q - 1'b1;
								state_q <= ST_ROOT;
							end
						end else begin
							out_q <= '{result_value: '0, status: STATUS_OK};
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_ROOT: state_q <= ST_ROOTW;
				ST_ROOTW: begin
					// root of the worked heap; its link is the partner
					res_q <= rv;
					partner_q <= rl;
					if (last_q == '0) begin
						out_q <= '{result_value: rv, status: STATUS_OK};
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_RDLAST: state_q <= ST_LAST;
				ST_LAST: begin
					// last entry fills the hole left by the removed one
					cur_val_q <= rv;
					cur_link_q <= rl;
					up_done_q <= 1'b0;
					if (pass2_q) begin
						hole_q <= partner_q;
						state_q <= (partner_q != '0) ? ST_UP : ST_DNL;
					end else begin
						hole_q <= '0;
						state_q <= ST_DNL;
					end
				end
				ST_UP: state_q <= ST_UPC;
				ST_UPC: begin
					if (goes_first(cur_val_q, rv, mx_q)) begin
						nb_pos_q <= parent;
						nb_val_q <= rv;
						nb_link_q <= rl;
						up_done_q <= 1'b1;
						state_q <= ST_MOVE;
					end else begin
						state_q <= up_done_q ? ST_PLACE : ST_DNL;
					end
				end
				ST_DNL: begin
					state_q <= (lc_w >= size_ext) ? ST_PLACE : ST_DNR;
				end
				ST_DNR: begin
					left_val_q <= rv;
					left_link_q <= rl;
					state_q <= ST_DNC;
				end
				ST_DNC: begin
					if (goes_first(best_val, cur_val_q, mx_q)) begin
						nb_pos_q <= best_pos;
						nb_val_q <= best_val;
						nb_link_q <= best_link;
						state_q <= ST_MOVE;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_MOVE: begin
					// continue from the neighbor's old spot
					hole_q <= nb_pos_q;
					if (up_done_q) begin
						state_q <= (nb_pos_q != '0) ? ST_UP : ST_PLACE;
					end else begin
						state_q <= ST_DNL;
					end
				end
				ST_PLACE: begin
					if (!pass2_q) begin
						pass2_q <= 1'b1;
						if (func_q == FUNC_INSERT) begin
							// same value into the max heap, linked to its min slot
							mx_q <= 1'b1;
							cur_link_q <= hole_q;
							hole_q <= last_q;
							up_done_q <= 1'b0;
							state_q <= (last_q != '0) ? ST_UP : ST_PLACE;
						end else if (partner_q == last_q) begin
							out_q <= '{result_value: res_q, status: STATUS_OK};
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							mx_q <= !mx_q;
							state_q <= ST_RDLAST;
						end
					end else begin
						out_q <= '{result_value: res_q, status: STATUS_OK};
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Sequencer state stays one-hot
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	// Count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CAP_C)
		else $error("entry count overflow");
	// No new item accepted while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> in_stall)
		else $error("accept while result pending");
	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");
endmodule

[bench/tb.sv]
// Self-checking bench for double_ended_priority_queue_unit: directed and random inserts and extracts.
// Depends on depq_pkg and double_ended_priority_queue_unit; the queue contents are tracked in a sorted array.
`timescale 1ns / 1ps

module tb;
	import depq_pkg::*;

	class depq_scoreboard;
		int signed queue_vals[$];	// kept sorted ascending
		depq_out_t pending[$];
		int mismatches;
		int capacity;

		function new(int cap);
			capacity = cap;
			mismatches = 0;
		endfunction

		// Work out the result of one accepted operation and store it.
		function void note_operation(depq_in_t item);
			depq_out_t r;
			int pos;
			r.result_value = '0;
			r.status = STATUS_OK;
			case (item.func)
				FUNC_INSERT: begin
					if (queue_vals.size() >= capacity) begin
						r.status = STATUS_FULL;
					end else begin
						pos = 0;
						while (pos < queue_vals.size() && queue_vals[pos] < item.value) pos++;
						queue_vals.insert(pos, item.value);
					end
				end
				FUNC_EXT_MIN: begin
					if (queue_vals.size() == 0) r.status = STATUS_EMPTY;
					else r.result_value = queue_vals.pop_front();
				end
				FUNC_EXT_MAX: begin
					if (queue_vals.size() == 0) begin
						r.status = STATUS_EMPTY;
					end else begin
						r.result_value = queue_vals[queue_vals.size() - 1];
						queue_vals.delete(queue_vals.size() - 1);
					end
				end
				default: ;
			endcase
			pending.insert(pending.size(), r);
		endfunction

		// Compare one result with the oldest expectation.
		function void check_result(depq_out_t got);
			depq_out_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d status %0d",
						got.result_value, got.status);
				return;
			end
			exp_r = pending.pop_front();
			if (got.result_value !== exp_r.result_value || got.status !== exp_r.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp value %0d status %0d, got value %0d status %0d",
						exp_r.result_value, exp_r.status, got.result_value, got.status);
			end
		endfunction
	endclass

	localparam int QCAP = 1024;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	depq_in_t in_data;
	logic out_valid;
	logic out_stall;
	depq_out_t out_data;

	depq_scoreboard sb;
	bit stall_mode;

	double_ended_priority_queue_unit #(.CAPACITY(QCAP)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Stall the result channel at random: none, light or heavy, heavy only in stall mode.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 2))
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
			endcase
		end
	end

	// Check each result transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Present one operation and hold it until the transfer.
	task automatic send_op(logic [1:0] f, logic signed [31:0] v);
		depq_in_t item;
		item.func = f;
		item.value = v;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_operation(item);
	endtask

	// Drop valid for a random gap.
	task automatic idle_gap(int max_cycles);
		int n;
		n = $urandom_range(0, max_cycles);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 15)) - 8;
			default: return $signed($urandom());
		endcase
	endfunction

	initial begin
		int burst;
		int sent;
		int k;
		sb = new(QCAP);
		stall_mode = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty extracts, extremes, duplicates, unused code.
		send_op(FUNC_EXT_MIN, 0);
		send_op(FUNC_EXT_MAX, 0);
		send_op(FUNC_INSERT, 32'sh7fffffff);
		send_op(FUNC_INSERT, 32'sh80000000);
		send_op(FUNC_INSERT, 0);
		send_op(FUNC_INSERT, -1);
		send_op(FUNC_INSERT, -1);
		send_op(FUNC_NONE, 32'sh12345678);
		send_op(FUNC_EXT_MIN, 0);
		send_op(FUNC_EXT_MAX, 0);
		send_op(FUNC_EXT_MIN, 0);
		send_op(FUNC_EXT_MIN, 0);
		send_op(FUNC_EXT_MAX, 0);
		send_op(FUNC_EXT_MAX, 0);
		drain_results();

		// Fill to capacity, hit full, then mixed extracts from a full queue.
		stall_mode = 1'b1;
		for (k = 0; k < QCAP; k++) begin
			send_op(FUNC_INSERT, rand_value());
			if ($urandom_range(0, 7) == 0) idle_gap(4);
		end
		send_op(FUNC_INSERT, 5);
		send_op(FUNC_INSERT, -5);
		drain_results();
		for (k = 0; k < 300; k++) begin
			send_op($urandom_range(0, 1) ? FUNC_EXT_MIN : FUNC_EXT_MAX, $signed($urandom()));
			if ($urandom_range(0, 7) == 0) idle_gap(4);
		end

		// Random mix in bursts, with a bias that alternates between inserts and extracts.
		sent = 0;
		while (sent < 700) begin
			burst = $urandom_range(1, 30);
			stall_mode = $urandom_range(0, 1);
			repeat (burst) begin
				k = $urandom_range(0, 99);
				if (k < ((sent / 250) % 2 ? 35 : 65))
					send_op(FUNC_INSERT, rand_value());
				else if (k < 97)
					send_op($urandom_range(0, 1) ? FUNC_EXT_MIN : FUNC_EXT_MAX,
						$signed($urandom()));
				else
					send_op(FUNC_NONE, $signed($urandom()));
				sent++;
			end
			idle_gap(20);
		end
		drain_results();
		repeat (100) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
